// ===== hw/rtl/ctsc_pkg.sv =====
package ctsc_pkg;

  // item opcodes
  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_ENTER  = 3'd1;
  localparam logic [2:0] OP_PLUS   = 3'd2;
  localparam logic [2:0] OP_MINUS  = 3'd3;
  localparam logic [2:0] OP_ESCAPE = 3'd4;
  localparam logic [2:0] OP_LOAD   = 3'd5;

  // edited field codes
  localparam logic [1:0] FIELD_NONE    = 2'd0;
  localparam logic [1:0] FIELD_HOURS   = 2'd1;
  localparam logic [1:0] FIELD_MINUTES = 2'd2;
  localparam logic [1:0] FIELD_SECONDS = 2'd3;

  // stage mark bits
  localparam logic [2:0] MARK_H = 3'b001;
  localparam logic [2:0] MARK_M = 3'b010;
  localparam logic [2:0] MARK_S = 3'b100;

  // time limits
  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [5:0] MINSEC_MAX = 6'd59;
  localparam logic [4:0] HALF_DAY   = 5'd12;

  // register map, byte address = 4 * index
  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_SHOW_HOURS   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SHOW_MINUTES = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SHOW_SECONDS = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TWELVE_HOUR  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_KEYS_ENABLED = 3'd4;

  typedef struct packed {
    logic show_hours;
    logic show_minutes;
    logic show_seconds;
    logic twelve_hour_display;
    logic keys_enabled;
  } ctsc_cfg_t;

  typedef struct packed {
    logic [4:0] run_hours;
    logic [5:0] run_minutes;
    logic [5:0] run_seconds;
    logic [4:0] edit_hours;
    logic [5:0] edit_minutes;
    logic [5:0] edit_seconds;
    logic [2:0] stage_marks;
  } ctsc_state_t;

  typedef struct packed {
    logic [4:0] shown_hours;
    logic [5:0] shown_minutes;
    logic [5:0] shown_seconds;
    logic [1:0] edit_field;
    logic       time_committed;
  } ctsc_result_t;

endpackage

// ===== hw/rtl/ctsc_cfg.sv =====
module ctsc_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ctsc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output ctsc_pkg::ctsc_cfg_t         cfg
);
  import ctsc_pkg::*;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.show_hours          <= 1'b1;
      cfg.show_minutes        <= 1'b1;
      cfg.show_seconds        <= 1'b1;
      cfg.twelve_hour_display <= 1'b0;
      cfg.keys_enabled        <= 1'b1;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SHOW_HOURS:   cfg.show_hours          <= pwdata[0];
        REG_SHOW_MINUTES: cfg.show_minutes        <= pwdata[0];
        REG_SHOW_SECONDS: cfg.show_seconds        <= pwdata[0];
        REG_TWELVE_HOUR:  cfg.twelve_hour_display <= pwdata[0];
        REG_KEYS_ENABLED: cfg.keys_enabled        <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    prdata = 32'd0;
    unique case (reg_idx)
      REG_SHOW_HOURS:   prdata[0] = cfg.show_hours;
      REG_SHOW_MINUTES: prdata[0] = cfg.show_minutes;
      REG_SHOW_SECONDS: prdata[0] = cfg.show_seconds;
      REG_TWELVE_HOUR:  prdata[0] = cfg.twelve_hour_display;
      REG_KEYS_ENABLED: prdata[0] = cfg.keys_enabled;
      default:          prdata    = 32'd0;
    endcase
  end

endmodule

// ===== hw/rtl/ctsc_step.sv =====
module ctsc_step (
  input  ctsc_pkg::ctsc_cfg_t    cfg,
  input  ctsc_pkg::ctsc_state_t  st,
  input  logic [2:0]             opcode,
  input  logic [7:0]             load_hours,
  input  logic [7:0]             load_minutes,
  input  logic [7:0]             load_seconds,
  output ctsc_pkg::ctsc_state_t  st_next,
  output ctsc_pkg::ctsc_result_t res
);
  import ctsc_pkg::*;

  function automatic logic [1:0] field_of(input logic [2:0] marks);
    logic [1:0] f;
    if (marks == 3'b000)           f = FIELD_NONE;
    else if ((marks & MARK_M) == 0) f = FIELD_HOURS;
    else if ((marks & MARK_S) == 0) f = FIELD_MINUTES;
    else                           f = FIELD_SECONDS;
    return f;
  endfunction

  function automatic logic [5:0] wrap_up(input logic [5:0] v, input logic [5:0] top);
    return (v >= top) ? 6'd0 : v + 6'd1;
  endfunction

  function automatic logic [5:0] wrap_down(input logic [5:0] v, input logic [5:0] top);
    return (v == 6'd0 || v > top) ? top : v - 6'd1;
  endfunction

  logic       load_ok;
  logic       committed;
  logic [1:0] cur_field;
  logic [1:0] new_field;
  logic [4:0] sh;
  logic [5:0] sm;
  logic [5:0] ss;
  logic [5:0] hour_wide;

  assign load_ok = (load_hours <= {3'd0, HOUR_MAX}) && (load_minutes <= {2'd0, MINSEC_MAX})
                   && (load_seconds <= {2'd0, MINSEC_MAX});
  assign cur_field = field_of(st.stage_marks);

  // next state for one item
  always_comb begin
    st_next   = st;
    committed = 1'b0;
    hour_wide = 6'd0;
    unique case (opcode)
      OP_TICK: begin
        if (st.run_seconds >= MINSEC_MAX) begin
          st_next.run_seconds = 6'd0;
          if (st.run_minutes >= MINSEC_MAX) begin
            st_next.run_minutes = 6'd0;
            st_next.run_hours   = (st.run_hours >= HOUR_MAX) ? 5'd0 : st.run_hours + 5'd1;
          end else begin
            st_next.run_minutes = st.run_minutes + 6'd1;
          end
        end else begin
          st_next.run_seconds = st.run_seconds + 6'd1;
        end
      end
      OP_LOAD: begin
        if (load_ok) begin
          st_next.run_hours   = load_hours[4:0];
          st_next.run_minutes = load_minutes[5:0];
          st_next.run_seconds = load_seconds[5:0];
        end
      end
      OP_ENTER: begin
        if (cfg.keys_enabled) begin
          // first enter takes a copy of the running time
          if (st.stage_marks == 3'b000) begin
            st_next.edit_hours   = st.run_hours;
            st_next.edit_minutes = st.run_minutes;
            st_next.edit_seconds = st.run_seconds;
          end
          if (cfg.show_hours && (st.stage_marks & MARK_H) == 0) begin
            st_next.stage_marks = st.stage_marks | MARK_H;
          end else if (cfg.show_minutes && (st.stage_marks & MARK_M) == 0) begin
            st_next.stage_marks = st.stage_marks | MARK_H | MARK_M;
          end else if (cfg.show_seconds && (st.stage_marks & MARK_S) == 0) begin
            st_next.stage_marks = st.stage_marks | MARK_H | MARK_M | MARK_S;
          end else begin
            // commit the edit copy
            st_next.run_hours   = st_next.edit_hours;
            st_next.run_minutes = st_next.edit_minutes;
            st_next.run_seconds = st_next.edit_seconds;
            st_next.stage_marks = 3'b000;
            committed           = 1'b1;
          end
        end
      end
      OP_PLUS: begin
        if (cfg.keys_enabled) begin
          case (cur_field)
            FIELD_HOURS: begin
              hour_wide          = wrap_up({1'b0, st.edit_hours}, {1'b0, HOUR_MAX});
              st_next.edit_hours = hour_wide[4:0];
            end
            FIELD_MINUTES: st_next.edit_minutes = wrap_up(st.edit_minutes, MINSEC_MAX);
            FIELD_SECONDS: st_next.edit_seconds = wrap_up(st.edit_seconds, MINSEC_MAX);
            default: ;
          endcase
        end
      end
      OP_MINUS: begin
        if (cfg.keys_enabled) begin
          case (cur_field)
            FIELD_HOURS: begin
              hour_wide          = wrap_down({1'b0, st.edit_hours}, {1'b0, HOUR_MAX});
              st_next.edit_hours = hour_wide[4:0];
            end
            FIELD_MINUTES: st_next.edit_minutes = wrap_down(st.edit_minutes, MINSEC_MAX);
            FIELD_SECONDS: st_next.edit_seconds = wrap_down(st.edit_seconds, MINSEC_MAX);
            default: ;
          endcase
        end
      end
      OP_ESCAPE: begin
        if (cfg.keys_enabled) st_next.stage_marks = 3'b000;
      end
      default: ;
    endcase
  end

  // shown time after the item
  assign new_field = field_of(st_next.stage_marks);

  always_comb begin
    if (new_field != FIELD_NONE) begin
      sh = st_next.edit_hours;
      sm = st_next.edit_minutes;
      ss = st_next.edit_seconds;
    end else begin
      sh = st_next.run_hours;
      sm = st_next.run_minutes;
      ss = st_next.run_seconds;
    end
    if (cfg.twelve_hour_display && sh >= HALF_DAY) sh = sh - HALF_DAY;
    res.shown_hours    = sh;
    res.shown_minutes  = sm;
    res.shown_seconds  = ss;
    res.edit_field     = new_field;
    res.time_committed = committed;
  end

endmodule

// ===== hw/rtl/clock_time_setting_controller_unit.sv =====
// channel   | signals                                              | direction
// ----------+------------------------------------------------------+----------
// item      | item_valid/item_ready, opcode, load_*                | in
// result    | result_valid/result_ready, shown_*, edit_field,      | out
//           | time_committed                                       |
// config    | psel/penable/pwrite/paddr/pwdata/prdata/pready       | in/out
//
// one request per clock sustained while result_ready holds; a stalled result holds accepted requests back
// the step logic sits between the request register and the result register
// rst is synchronous: time 00:00:00, not editing, all fields shown, 24-hour, keys on
// a stalled result holds the step; the request register still takes one more request
module clock_time_setting_controller_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  logic [2:0]                  opcode,
  input  logic [7:0]                  load_hours,
  input  logic [7:0]                  load_minutes,
  input  logic [7:0]                  load_seconds,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [4:0]                  shown_hours,
  output logic [5:0]                  shown_minutes,
  output logic [5:0]                  shown_seconds,
  output logic [1:0]                  edit_field,
  output logic                        time_committed,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ctsc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import ctsc_pkg::*;

  ctsc_cfg_t    cfg;
  ctsc_state_t  st;
  ctsc_state_t  st_next;
  ctsc_result_t res;

  logic       item_full;
  logic [2:0] op_q;
  logic [7:0] lh_q;
  logic [7:0] lm_q;
  logic [7:0] ls_q;
  logic       advance;

  assign advance    = item_full && (!result_valid || result_ready);
  assign item_ready = !item_full || advance;

  ctsc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (item_valid && item_ready) begin
      item_full <= 1'b1;
    end else if (advance) begin
      item_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      op_q <= opcode;
      lh_q <= load_hours;
      lm_q <= load_minutes;
      ls_q <= load_seconds;
    end
  end

  ctsc_step u_step (
    .cfg          (cfg),
    .st           (st),
    .opcode       (op_q),
    .load_hours   (lh_q),
    .load_minutes (lm_q),
    .load_seconds (ls_q),
    .st_next      (st_next),
    .res          (res)
  );

  // clock and edit state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      shown_hours    <= res.shown_hours;
      shown_minutes  <= res.shown_minutes;
      shown_seconds  <= res.shown_seconds;
      edit_field     <= res.edit_field;
      time_committed <= res.time_committed;
    end
  end

endmodule

// ===== hw/rtl/ctsc_checker.sv =====
module ctsc_checker (
  input logic       clk,
  input logic       rst,
  input logic       result_valid,
  input logic       result_ready,
  input logic [4:0] shown_hours,
  input logic [5:0] shown_minutes,
  input logic [5:0] shown_seconds,
  input logic [1:0] edit_field,
  input logic       time_committed
);
  import ctsc_pkg::*;

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  // a stalled result keeps its time
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=>
      (result_valid && $stable(shown_hours) && $stable(shown_minutes)
       && $stable(shown_seconds) && $stable(edit_field)))
    else $error("stalled result changed");

  // shown time stays in range
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (shown_hours <= HOUR_MAX && shown_minutes <= MINSEC_MAX
                      && shown_seconds <= MINSEC_MAX))
    else $error("shown time out of range");

  // a commit always leaves edit mode
  a_commit_exit: assert property (@(posedge clk) disable iff (rst)
    (result_valid && time_committed) |-> edit_field == FIELD_NONE)
    else $error("commit while still editing");

endmodule

bind clock_time_setting_controller_unit ctsc_checker u_ctsc_checker (.*);

// ===== tb/sv/tb_clock_time_setting_controller_unit.sv =====
module tb_clock_time_setting_controller_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ctsc_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int RAND_PER_SETTING = 78;
  localparam int NUM_SETTINGS = 8;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] hours;
    logic [7:0] minutes;
    logic [7:0] seconds;
  } clock_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                item_valid = 1'b0;
  logic                item_ready;
  logic [2:0]          opcode = OP_TICK;
  logic [7:0]          load_hours = '0;
  logic [7:0]          load_minutes = '0;
  logic [7:0]          load_seconds = '0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  logic [4:0]          shown_hours;
  logic [5:0]          shown_minutes;
  logic [5:0]          shown_seconds;
  logic [1:0]          edit_field;
  logic                time_committed;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  clock_time_setting_controller_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .opcode         (opcode),
    .load_hours     (load_hours),
    .load_minutes   (load_minutes),
    .load_seconds   (load_seconds),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .shown_hours    (shown_hours),
    .shown_minutes  (shown_minutes),
    .shown_seconds  (shown_seconds),
    .edit_field     (edit_field),
    .time_committed (time_committed),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // model of the clock: settings, running time, edit copy and marks
  ctsc_cfg_t  clk_cfg = 5'b11101;
  logic [4:0] run_h = '0;
  logic [5:0] run_m = '0;
  logic [5:0] run_s = '0;
  logic [4:0] ed_h = '0;
  logic [5:0] ed_m = '0;
  logic [5:0] ed_s = '0;
  logic [2:0] marks = '0;

  clock_req_t   pending_reqs[$];
  ctsc_result_t shown_q[$];

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  logic item_taken = 1'b0;
  int  mismatches = 0;
  int  n_results = 0;
  int  n_commits = 0;
  int  n_settings = 0;
  int  quiet_cycles = 0;

  function automatic logic [5:0] wrap_up(logic [5:0] v, logic [5:0] top);
    return (v >= top) ? 6'd0 : v + 6'd1;
  endfunction

  function automatic logic [5:0] wrap_down(logic [5:0] v, logic [5:0] top);
    return (v == 6'd0 || v > top) ? top : v - 6'd1;
  endfunction

  function automatic logic [1:0] field_of(logic [2:0] m);
    if (m == '0) return FIELD_NONE;
    if ((m & MARK_M) == '0) return FIELD_HOURS;
    if ((m & MARK_S) == '0) return FIELD_MINUTES;
    return FIELD_SECONDS;
  endfunction

  // apply one request to the model and return the display it produces
  function automatic ctsc_result_t step_clock(clock_req_t rq);
    ctsc_result_t r;
    logic         committed;
    logic [1:0]   fld;
    logic [4:0]   sh;
    committed = 1'b0;
    if (rq.op == OP_TICK) begin
      run_s = run_s + 6'd1;
      if (run_s > MINSEC_MAX) begin
        run_s = '0;
        run_m = run_m + 6'd1;
        if (run_m > MINSEC_MAX) begin
          run_m = '0;
          run_h = run_h + 5'd1;
          if (run_h > HOUR_MAX) run_h = '0;
        end
      end
    end else if (rq.op == OP_LOAD) begin
      if (rq.hours <= HOUR_MAX && rq.minutes <= MINSEC_MAX && rq.seconds <= MINSEC_MAX) begin
        run_h = rq.hours[4:0];
        run_m = rq.minutes[5:0];
        run_s = rq.seconds[5:0];
      end
    end else if (rq.op >= OP_ENTER && rq.op <= OP_ESCAPE && clk_cfg.keys_enabled) begin
      fld = field_of(marks);
      case (rq.op)
        OP_ENTER: begin
          if (marks == '0) begin
            ed_h = run_h;
            ed_m = run_m;
            ed_s = run_s;
          end
          if (clk_cfg.show_hours && (marks & MARK_H) == '0) begin
            marks = marks | MARK_H;
          end else if (clk_cfg.show_minutes && (marks & MARK_M) == '0) begin
            marks = marks | MARK_H | MARK_M;
          end else if (clk_cfg.show_seconds && (marks & MARK_S) == '0) begin
            marks = marks | MARK_H | MARK_M | MARK_S;
          end else begin
            run_h = ed_h;
            run_m = ed_m;
            run_s = ed_s;
            marks = '0;
            committed = 1'b1;
          end
        end
        OP_PLUS: begin
          if (fld == FIELD_HOURS) ed_h = 5'(wrap_up(6'(ed_h), 6'(HOUR_MAX)));
          else if (fld == FIELD_MINUTES) ed_m = wrap_up(ed_m, MINSEC_MAX);
          else if (fld == FIELD_SECONDS) ed_s = wrap_up(ed_s, MINSEC_MAX);
        end
        OP_MINUS: begin
          if (fld == FIELD_HOURS) ed_h = 5'(wrap_down(6'(ed_h), 6'(HOUR_MAX)));
          else if (fld == FIELD_MINUTES) ed_m = wrap_down(ed_m, MINSEC_MAX);
          else if (fld == FIELD_SECONDS) ed_s = wrap_down(ed_s, MINSEC_MAX);
        end
        default: marks = '0;
      endcase
    end
    fld = field_of(marks);
    if (fld != FIELD_NONE) begin
      sh = ed_h;
      r.shown_minutes = ed_m;
      r.shown_seconds = ed_s;
    end else begin
      sh = run_h;
      r.shown_minutes = run_m;
      r.shown_seconds = run_s;
    end
    if (clk_cfg.twelve_hour_display && sh >= HALF_DAY) sh = sh - HALF_DAY;
    r.shown_hours = sh;
    r.edit_field = fld;
    r.time_committed = committed;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < 50) $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [5:0] got, logic [5:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0d want %0d", n_results, name, got, want));
  endtask

  // request driver, fed from the pending queue
  always @(negedge clk) begin
    clock_req_t rq;
    if (rst) begin
      item_valid <= 1'b0;
      result_ready <= 1'b0;
    end else begin
      if (!item_valid || item_taken) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          rq = pending_reqs.pop_front();
          item_valid <= 1'b1;
          opcode <= rq.op;
          load_hours <= rq.hours;
          load_minutes <= rq.minutes;
          load_seconds <= rq.seconds;
        end else begin
          item_valid <= 1'b0;
        end
      end
      result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: predict on accepted requests, compare accepted results
  always @(posedge clk) begin
    ctsc_result_t want;
    ctsc_result_t got;
    if (rst) begin
      item_taken <= 1'b0;
    end else begin
      item_taken <= item_valid && item_ready;
      if (result_valid && result_ready) begin
        got = '{shown_hours, shown_minutes, shown_seconds, edit_field, time_committed};
        n_results++;
        if (shown_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no request pending", n_results));
        end else begin
          want = shown_q.pop_front();
          check_field("shown_hours", 6'(got.shown_hours), 6'(want.shown_hours));
          check_field("shown_minutes", got.shown_minutes, want.shown_minutes);
          check_field("shown_seconds", got.shown_seconds, want.shown_seconds);
          check_field("edit_field", 6'(got.edit_field), 6'(want.edit_field));
          check_field("time_committed", 6'(got.time_committed), 6'(want.time_committed));
          if (want.time_committed) n_commits++;
        end
      end
      if (item_valid && item_ready)
        shown_q.push_back(step_clock('{opcode, load_hours, load_minutes, load_seconds}));
    end
  end

  // watchdog on cycles where no request and no result moves
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_req(logic [2:0] op, logic [7:0] h, logic [7:0] m, logic [7:0] s);
    pending_reqs.push_back('{op, h, m, s});
  endtask

  // wait until every request is out and answered, then let the pipe settle
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || item_valid || shown_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // apb write: setup then access, pready is always high
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx) << 2;
    pwdata <= {31'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SHOW_HOURS:   clk_cfg.show_hours = val;
      REG_SHOW_MINUTES: clk_cfg.show_minutes = val;
      REG_SHOW_SECONDS: clk_cfg.show_seconds = val;
      REG_TWELVE_HOUR:  clk_cfg.twelve_hour_display = val;
      default:          clk_cfg.keys_enabled = val;
    endcase
  endtask

  task automatic apply_setting(ctsc_cfg_t c);
    write_reg(REG_SHOW_HOURS, c.show_hours);
    write_reg(REG_SHOW_MINUTES, c.show_minutes);
    write_reg(REG_SHOW_SECONDS, c.show_seconds);
    write_reg(REG_TWELVE_HOUR, c.twelve_hour_display);
    write_reg(REG_KEYS_ENABLED, c.keys_enabled);
    n_settings++;
  endtask

  // random request, mostly edit traffic, ticks and loads near the carries
  function automatic clock_req_t rand_req();
    clock_req_t rq;
    int pick;
    pick = $urandom_range(99);
    rq.hours = 8'($urandom);
    rq.minutes = 8'($urandom);
    rq.seconds = 8'($urandom);
    if (pick < 30) rq.op = OP_TICK;
    else if (pick < 55) rq.op = OP_ENTER;
    else if (pick < 70) rq.op = OP_PLUS;
    else if (pick < 80) rq.op = OP_MINUS;
    else if (pick < 85) rq.op = OP_ESCAPE;
    else if (pick < 95) begin
      rq.op = OP_LOAD;
      if ($urandom_range(9) != 0) begin
        rq.hours = $urandom_range(1) ? 8'($urandom_range(23)) : 8'(HOUR_MAX);
        rq.minutes = $urandom_range(1) ? 8'($urandom_range(59)) : 8'(MINSEC_MAX);
        rq.seconds = $urandom_range(1) ? 8'($urandom_range(59)) : 8'(MINSEC_MAX);
      end
    end else begin
      rq.op = $urandom_range(1) ? 3'd6 : 3'd7;
    end
    return rq;
  endfunction

  ctsc_cfg_t setting_list[NUM_SETTINGS];

  initial begin
    // hours hidden mid-edit first, then none shown, keys off, the full set last
    setting_list[0] = 5'b01111;
    setting_list[1] = 5'b00011;
    setting_list[2] = 5'($urandom);
    setting_list[3] = 5'b11110;
    setting_list[4] = 5'b00101;
    setting_list[5] = 5'($urandom);
    setting_list[6] = 5'b11011;
    setting_list[7] = 5'b11101;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 19;
    recv_stall_pct = 84;

    // directed: day wrap, rejected loads, unused codes, idle keys
    queue_req(OP_LOAD, 8'd23, 8'd59, 8'd58);
    queue_req(OP_TICK, 8'hff, 8'hff, 8'hff);
    queue_req(OP_TICK, 8'h00, 8'h00, 8'h00);
    queue_req(OP_LOAD, 8'd24, 8'd0, 8'd0);
    queue_req(OP_LOAD, 8'd0, 8'd60, 8'd0);
    queue_req(OP_LOAD, 8'd0, 8'd0, 8'd60);
    queue_req(OP_LOAD, 8'hff, 8'hff, 8'hff);
    queue_req(3'd6, 8'd1, 8'd2, 8'd3);
    queue_req(3'd7, 8'hff, 8'hff, 8'hff);
    queue_req(OP_PLUS, 8'd0, 8'd0, 8'd0);
    queue_req(OP_MINUS, 8'd0, 8'd0, 8'd0);
    queue_req(OP_ESCAPE, 8'd0, 8'd0, 8'd0);
    // directed: a full edit pass with wraps at both ends of every field
    queue_req(OP_LOAD, 8'd23, 8'd0, 8'd59);
    queue_req(OP_ENTER, 8'd0, 8'd0, 8'd0);
    queue_req(OP_PLUS, 8'd0, 8'd0, 8'd0);
    queue_req(OP_MINUS, 8'd0, 8'd0, 8'd0);
    queue_req(OP_TICK, 8'd0, 8'd0, 8'd0);
    queue_req(OP_LOAD, 8'd0, 8'd0, 8'd0);
    queue_req(OP_ENTER, 8'd0, 8'd0, 8'd0);
    queue_req(OP_MINUS, 8'd0, 8'd0, 8'd0);
    queue_req(OP_PLUS, 8'd0, 8'd0, 8'd0);
    queue_req(OP_ENTER, 8'd0, 8'd0, 8'd0);
    queue_req(OP_PLUS, 8'd0, 8'd0, 8'd0);
    queue_req(OP_MINUS, 8'd0, 8'd0, 8'd0);
    queue_req(OP_ENTER, 8'd0, 8'd0, 8'd0);
    // escape drops an edit, then leave one open for the next setting
    queue_req(OP_ENTER, 8'd0, 8'd0, 8'd0);
    queue_req(OP_ESCAPE, 8'd0, 8'd0, 8'd0);
    queue_req(OP_ENTER, 8'd0, 8'd0, 8'd0);
    wait_drained();

    // random phases, each under its own register setting
    for (int p = 0; p < NUM_SETTINGS; p++) begin
      if (p == 3) begin
        send_idle_pct = 84;
        recv_stall_pct = 19;
      end else if (p == 6) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      apply_setting(setting_list[p]);
      for (int i = 0; i < RAND_PER_SETTING; i++) pending_reqs.push_back(rand_req());
      wait_drained();
    end

    repeat (8) @(negedge clk);
    if (shown_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", shown_q.size()));
    $display("checked %0d displayed results, %0d of them edit commits", n_results, n_commits);
    $display("ran under %0d register settings, %0d mismatches", n_settings, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== clock_time_setting_controller_unit.f =====
hw/rtl/ctsc_pkg.sv
hw/rtl/ctsc_cfg.sv
hw/rtl/ctsc_step.sv
hw/rtl/clock_time_setting_controller_unit.sv
hw/rtl/ctsc_checker.sv
tb/sv/tb_clock_time_setting_controller_unit.sv
